[sv/rcam_pkg.sv]
package rcam_pkg;

    localparam int COORD_W    = 10;
    localparam int RADIUS_W   = 11;
    localparam int ALPHA_W    = 8;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_RADIUS = 1024;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);
    localparam logic [RADIUS_W-1:0] RADIUS_MAX   = RADIUS_W'(MAX_RADIUS);

    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int ARG_W      = SUM_W + 2 * FRAC_BITS + 1;
    localparam int ROOT_W     = ARG_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEPS      = 2;
    localparam int SQ_STAGES  = (ROOT_W + STEPS - 1) / STEPS;
    localparam int DIFF_W     = ROOT_W + 1;
    localparam int NEG_W      = FRAC_BITS + 1;
    localparam int PROD_W     = NEG_W + FRAC_BITS;

    localparam int S_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((ALPHA_W + 7) / 8) * 8;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st, input logic [1:0] pair);
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        sqrt_state_t      res;
        shifted = {st.rem, pair};
        trial   = (REM_W+2)'({st.root, 2'b01});
        if (shifted >= trial) begin
            res.rem  = REM_W'(shifted - trial);
            res.root = {st.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = REM_W'(shifted);
            res.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[sv/rounded_corner_alpha_mask.sv]
// Channel  | Ports                    | Beat contents
// s_       | s_tvalid/tready/tdata    | pixel coordinate (row, col)
// m_       | m_tvalid/tready/tdata    | coverage alpha
// cfg_     | cfg_we/cfg_wdata         | corner radius
//
// One beat per clock is sustained while the output is not stalled; the square
// root resolves its 19 result bits two per pipeline stage over ten stages.
// Reset clears all valid bits and sets the radius to one.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
module rounded_corner_alpha_mask
    import rcam_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [RADIUS_W-1:0]    cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // row [9:0], col [19:10], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // alpha [7:0]
);

    logic                       adv;
    logic [RADIUS_W-1:0]        radius_reg;

    logic                       v1_reg;
    logic [SQ_W-1:0]            sq_row_reg;
    logic [SQ_W-1:0]            sq_col_reg;
    logic                       v2_reg;
    logic [SUM_W-1:0]           sum_reg;

    logic [SQ_STAGES-1:0]       vs_reg;
    sqrt_state_t                st_reg   [SQ_STAGES];
    sqrt_state_t                st_next  [SQ_STAGES];
    logic [SUM_W-1:0]           arg_reg  [SQ_STAGES];

    logic                       v3_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DIFF_W-1:0]   diff_next;
    logic [RADIUS_W-1:0]        r_sat;

    logic                       vo_reg;
    logic [ALPHA_W-1:0]         alpha_reg;
    logic [ALPHA_W-1:0]         alpha_next;
    logic [NEG_W-1:0]           neg;
    logic [PROD_W-1:0]          prod;

    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vo_reg;
    assign m_tdata  = M_TDATA_W'(alpha_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_we) begin
            radius_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_row_reg <= s_tdata[COORD_W-1:0] * s_tdata[COORD_W-1:0];
            sq_col_reg <= s_tdata[2*COORD_W-1:COORD_W] * s_tdata[2*COORD_W-1:COORD_W];
            sum_reg    <= SUM_W'(sq_row_reg) + SUM_W'(sq_col_reg);
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        logic [SUM_W-1:0] arg_in;
        sqrt_state_t      st_in;
        logic             v_in;
        logic [ARG_W-1:0] n;

        if (k == 0) begin : g_first
            assign arg_in = sum_reg;
            assign st_in  = '0;
            assign v_in   = v2_reg;
        end else begin : g_rest
            assign arg_in = arg_reg[k-1];
            assign st_in  = st_reg[k-1];
            assign v_in   = vs_reg[k-1];
        end

        assign n = {1'b0, arg_in, (2*FRAC_BITS)'(0)};

        always_comb begin
            sqrt_state_t st;
            int          idx;
            st = st_in;
            for (int j = 0; j < STEPS; j++) begin
                idx = ROOT_W - 1 - STEPS * k - j;
                if (idx >= 0) begin
                    st = sqrt_step(st, n[2*idx +: 2]);
                end
            end
            st_next[k] = st;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs_reg[k] <= 1'b0;
            end else if (adv) begin
                vs_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[k]  <= st_next[k];
                arg_reg[k] <= arg_in;
            end
        end
    end

    always_comb begin
        r_sat     = (radius_reg > RADIUS_MAX) ? RADIUS_MAX : radius_reg;
        diff_next = $signed({1'b0, st_reg[SQ_STAGES-1].root})
                  - $signed(DIFF_W'({r_sat, FRAC_BITS'(0)}));
    end

    always_comb begin
        neg  = NEG_W'(-diff_reg);
        prod = {neg, FRAC_BITS'(0)} - PROD_W'(neg);
        if (diff_reg > 0) begin
            alpha_next = '0;
        end else if (diff_reg >= -$signed(DIFF_W'(1 << FRAC_BITS))) begin
            alpha_next = prod[FRAC_BITS +: ALPHA_W];
        end else begin
            alpha_next = '1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= vs_reg[SQ_STAGES-1];
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            diff_reg  <= diff_next;
            alpha_reg <= alpha_next;
        end
    end

endmodule

[tb/tb_rounded_corner_alpha_mask.sv]
`timescale 1ns / 1ps

module tb_rounded_corner_alpha_mask;
    import rcam_pkg::*;

    localparam int PIPE_LAT      = 14;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 10;
    localparam int PHASE_PIXELS  = 195;

    typedef enum logic {
        ROW_PIXEL,
        ROW_RADIUS
    } dir_kind_e;

    typedef struct packed {
        dir_kind_e           kind;
        logic [RADIUS_W-1:0] radius;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic                typed;
        logic [ALPHA_W-1:0]  alpha;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd0,    1'b1, 8'd255},
        '{ROW_PIXEL,  11'd0,    10'd1,    10'd0,    1'b1, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd1,    1'b1, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd1,    10'd1,    1'b1, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd1023, 10'd1023, 1'b1, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd1023, 10'd0,    1'b1, 8'd0},
        '{ROW_RADIUS, 11'd0,    10'd0,    10'd0,    1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd0,    1'b1, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd1,    1'b1, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd512,  10'd512,  1'b1, 8'd0},
        '{ROW_RADIUS, 11'd1024, 10'd0,    10'd0,    1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd0,    1'b1, 8'd255},
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd1023, 1'b1, 8'd255},
        '{ROW_PIXEL,  11'd0,    10'd1023, 10'd0,    1'b1, 8'd255},
        '{ROW_PIXEL,  11'd0,    10'd1023, 10'd1023, 1'b1, 8'd0},
        '{ROW_RADIUS, 11'd2047, 10'd0,    10'd0,    1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd1023, 1'b1, 8'd255},
        '{ROW_PIXEL,  11'd0,    10'd1023, 10'd1023, 1'b1, 8'd0},
        '{ROW_RADIUS, 11'd5,    10'd0,    10'd0,    1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd3,    10'd4,    1'b1, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd0,    10'd4,    1'b1, 8'd255},
        '{ROW_PIXEL,  11'd0,    10'd2,    10'd4,    1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd4,    10'd4,    1'b0, 8'd0},
        '{ROW_RADIUS, 11'd1025, 10'd0,    10'd0,    1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd682,  10'd682,  1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd724,  10'd723,  1'b0, 8'd0},
        '{ROW_PIXEL,  11'd0,    10'd1023, 10'd5,    1'b0, 8'd0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [RADIUS_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;

    logic [ALPHA_W-1:0]    alpha_q [$];
    logic [ALPHA_W-1:0]    pending_alpha;
    logic [RADIUS_W-1:0]   cur_radius = RADIUS_RESET;
    int                    err_count  = 0;
    int                    burst_left = 1;
    int                    stall_cycles = 0;
    int                    rx_cycle   = 0;
    int                    rx_mode    = 0;

    rounded_corner_alpha_mask i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 24; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= n) begin
                root = cand;
            end
        end
        return root;
    endfunction

    function automatic logic [RADIUS_W-1:0] clamp_radius(input logic [RADIUS_W-1:0] rad);
        return (rad > RADIUS_MAX) ? RADIUS_MAX : rad;
    endfunction

    // Distance to the corner in fixed point with 8 fractional bits, compared against the radius.
    function automatic logic [ALPHA_W-1:0] coverage_alpha(input logic [COORD_W-1:0] px_row,
                                                          input logic [COORD_W-1:0] px_col,
                                                          input logic [RADIUS_W-1:0] rad);
        longint unsigned sum_sq;
        longint unsigned dist_fx;
        longint          edge_diff;
        longint          one_px;
        sum_sq    = longint'(px_row) * longint'(px_row) + longint'(px_col) * longint'(px_col);
        dist_fx   = int_sqrt(sum_sq << (2 * FRAC_BITS));
        edge_diff = longint'(dist_fx) - (longint'(clamp_radius(rad)) << FRAC_BITS);
        one_px    = longint'(1) << FRAC_BITS;
        if (edge_diff <= 0 && edge_diff >= -one_px) begin
            return ALPHA_W'((unsigned'(-edge_diff) * 255) >> FRAC_BITS);
        end else if (edge_diff > 0) begin
            return '0;
        end else begin
            return '1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [ALPHA_W-1:0] got,
                                   input logic [ALPHA_W-1:0] want);
        $display("MISMATCH at %0t: %s (alpha got %0d, expected %0d)", $realtime, what, got,
                 want);
        err_count++;
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] px_row, input logic [COORD_W-1:0] px_col,
                              input logic typed, input logic [ALPHA_W-1:0] typed_alpha);
        logic [ALPHA_W-1:0] want;
        int                 gap;
        want = typed ? typed_alpha : coverage_alpha(px_row, px_col, cur_radius);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({px_col, px_row});
        do @(posedge aclk); while (!s_tready);
        alpha_q.push_back(want);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
    endtask

    task automatic drain_pipe;
        s_tvalid <= 1'b0;
        while (alpha_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] rad);
        cfg_we    <= 1'b1;
        cfg_wdata <= rad;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cur_radius = rad;
    endtask

    // Most random pixels sit within a pixel of the circle so the edge ramp is exercised.
    task automatic send_random_pixel;
        int unsigned        pick;
        int                 eff;
        int                 px_row;
        int                 px_col;
        logic [COORD_W-1:0] r_bits;
        logic [COORD_W-1:0] c_bits;
        pick = $urandom_range(0, 99);
        eff  = int'(clamp_radius(cur_radius));
        if (pick < 55) begin
            px_row = $urandom_range(0, (eff > 1023) ? 1023 : eff);
            px_col = int'(int_sqrt(64'(eff * eff - px_row * px_row)));
            px_col = px_col + int'($urandom_range(0, 2)) - 1;
            if (px_col < 0) px_col = 0;
            if (px_col > 1023) px_col = 1023;
            if ($urandom_range(0, 1) == 1) begin
                r_bits = COORD_W'(px_col);
                c_bits = COORD_W'(px_row);
            end else begin
                r_bits = COORD_W'(px_row);
                c_bits = COORD_W'(px_col);
            end
        end else if (pick < 75) begin
            r_bits = COORD_W'($urandom_range(0, (eff > 1023) ? 1023 : eff));
            c_bits = COORD_W'($urandom_range(0, (eff > 1023) ? 1023 : eff));
        end else begin
            r_bits = COORD_W'($urandom);
            c_bits = COORD_W'($urandom);
        end
        send_pixel(r_bits, c_bits, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (alpha_q.size() == 0) begin
                report_mismatch("result beat with no pixel outstanding", m_tdata[ALPHA_W-1:0],
                                '0);
            end else begin
                pending_alpha = alpha_q.pop_front();
                if (m_tdata !== M_TDATA_W'(pending_alpha)) begin
                    report_mismatch("alpha differs", m_tdata[ALPHA_W-1:0], pending_alpha);
                end
            end
        end
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 128 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (rx_cycle % 4 != 3);
            end
            default: begin
                m_tready <= ((rx_cycle % 16) < 3);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TIMEOUT: no beat moved for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        logic [RADIUS_W-1:0] rad;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TBL[i].kind == ROW_RADIUS) begin
                drain_pipe();
                write_radius(DIR_TBL[i].radius);
            end else begin
                send_pixel(DIR_TBL[i].row, DIR_TBL[i].col, DIR_TBL[i].typed, DIR_TBL[i].alpha);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: rad = 11'd1;
                1: rad = 11'd0;
                2: rad = 11'd1024;
                3: rad = 11'd2047;
                4: rad = 11'd2;
                5: rad = 11'd1023;
                6: rad = RADIUS_W'($urandom_range(1025, 2047));
                default: rad = RADIUS_W'($urandom_range(1, 1024));
            endcase
            drain_pipe();
            write_radius(rad);
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                send_random_pixel();
            end
        end

        drain_pipe();
        if (err_count == 0 && alpha_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
sv/rcam_pkg.sv
sv/rounded_corner_alpha_mask.sv
tb/tb_rounded_corner_alpha_mask.sv
